>>> src/spt_pkg.sv
// Shared types and constants for the signal persistence tracker.
package spt_pkg;

  localparam int FREQ_W  = 22;
  localparam int PROTO_W = 8;
  localparam int CHAN_W  = 8;
  localparam int COUNT_W = 8;
  localparam int TOL_W   = 16;
  localparam int THR_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int ACT_W   = 3;
  localparam int OUTC_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [ACT_W-1:0] ACT_BEGIN = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PEAK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_END   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

  localparam logic [OUTC_W-1:0] OUTC_DONE    = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_MATCHED = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_ALLOC   = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_DROPPED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd3;

  localparam logic [TOL_W-1:0]  TOL_RESET       = 16'd200;
  localparam logic [THR_W-1:0]  THR_RESET       = 8'd3;
  localparam logic [FREQ_W-1:0] BAND_LOW_RESET  = 22'd902000;
  localparam logic [FREQ_W-1:0] BAND_HIGH_RESET = 22'd928000;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 5'd31;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [PROTO_W-1:0] proto;
    logic [CHAN_W-1:0]  chan;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic write;
    logic activate;
    logic deactivate;
    logic clear;
  } table_cmd_t;

endpackage

>>> src/spt_table.sv
// Track table: entry memory with one write and one registered read port, plus valid/active flags.
module spt_table import spt_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  table_cmd_t    cmd,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_entry,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_entry,
  output logic          rd_active
);

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] active;
  entry_t rd_q;
  logic   rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      active    <= '0;
      rd_valid  <= 1'b0;
      rd_active <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid  <= valid[rd_addr];
        rd_active <= active[rd_addr];
      end
      if (cmd.clear) begin
        valid  <= '0;
        active <= '0;
      end else begin
        if (cmd.write) begin
          valid[wr_addr] <= 1'b1;
        end
        if (cmd.activate) begin
          active[wr_addr] <= 1'b1;
        end else if (cmd.deactivate) begin
          active[wr_addr] <= 1'b0;
        end
      end
    end
  end

  assign rd_entry = rd_valid ? rd_q : '0;

endmodule

>>> src/signal_persistence_tracker_core.sv
// Signal persistence tracker: keeps a table of tracked spectral peaks and reports persistence.
// One item at a time. A begin-sweep or end-sweep item walks the table twice: a modify pass,
// then a counting pass. A peak item does a search pass, then a table-update step
// (S_UPDATE), then the counting pass. Clear, read and unknown actions take one counting pass.
// The result is offered from the output register, and the next item can be accepted once
// the result is offered. Each pass is paced by the single read port of the track table, which
// delivers one entry per cycle. The result waits in S_OUT while the output register stays full.
// Reset and clear empty the table at once through per-entry valid flags; there is no clearing
// pass. s_axis_tready is high only between items, while a finished result may still wait in
// the output register.
module signal_persistence_tracker_core import spt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // low to high: peak_frequency_khz[21:0], protocol_id[29:22], channel_number[37:30],
  // entry_index[41:38], zero pad
  input  logic [47:0]           s_axis_tdata,
  // action[2:0]
  input  logic [ACT_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low to high: slot[3:0], persistent_total[8:4], persistent_us[13:9],
  // entry_frequency_khz[35:14], entry_protocol_id[43:36], entry_channel[51:44],
  // entry_count[59:52], entry_active[60], zero pad
  output logic [63:0]           m_axis_tdata,
  // outcome[1:0]
  output logic [OUTC_W-1:0]     m_axis_tuser
);

  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_COUNT,
    S_OUT
  } state_t;

  state_t state;

  logic [TOL_W-1:0]  tol;
  logic [THR_W-1:0]  thr;
  logic [FREQ_W-1:0] band_low;
  logic [FREQ_W-1:0] band_high;

  logic [ACT_W-1:0]   act;
  logic [FREQ_W-1:0]  peak_freq;
  logic [PROTO_W-1:0] peak_proto;
  logic [CHAN_W-1:0]  peak_chan;
  logic [SLOT_W-1:0]  idx;

  logic [CW-1:0] issue_cnt;
  logic          dv;
  logic [IW-1:0] didx;
  logic          pass_done;

  logic               match;
  logic [IW-1:0]      hit;
  logic [COUNT_W-1:0] hit_count;
  logic               free;
  logic [IW-1:0]      free_idx;

  logic [OUTC_W-1:0]  outcome;
  logic [SLOT_W-1:0]  slot;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] us;
  entry_t             e_entry;
  logic               e_active;

  logic [OUTC_W-1:0]  res_outcome;
  logic [SLOT_W-1:0]  res_slot;
  logic [TOTAL_W-1:0] res_total;
  logic [TOTAL_W-1:0] res_us;
  entry_t             res_entry;
  logic               res_active;

  table_cmd_t    cmd;
  logic [IW-1:0] wr_addr;
  entry_t        wr_entry;
  logic          rd_en;
  entry_t        rd_entry;
  logic          rd_active;

  logic               s_accept;
  logic [FREQ_W-1:0]  diff;
  logic               near;
  logic               persistent;
  logic               in_band;
  logic [COUNT_W:0]   bumped;
  logic [COUNT_W-1:0] sat_count;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign rd_en         = ((state == S_SCAN) || (state == S_COUNT)) && (issue_cnt != LAST_CNT);
  assign pass_done     = (issue_cnt == LAST_CNT) && !dv;

  assign diff = (peak_freq >= rd_entry.freq) ? (peak_freq - rd_entry.freq)
                                             : (rd_entry.freq - peak_freq);
  assign near       = diff < FREQ_W'(tol);
  assign persistent = rd_active && (rd_entry.proto != '0) && (rd_entry.count >= thr);
  assign in_band    = (rd_entry.freq >= band_low) && (rd_entry.freq <= band_high);
  assign bumped     = {1'b0, hit_count} + (COUNT_W+1)'(2);
  assign sat_count  = bumped[COUNT_W] ? COUNT_MAX : bumped[COUNT_W-1:0];

  spt_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_en     (rd_en),
    .rd_addr   (issue_cnt[IW-1:0]),
    .rd_entry  (rd_entry),
    .rd_active (rd_active)
  );

  always_comb begin
    cmd      = '0;
    wr_addr  = didx;
    wr_entry = rd_entry;
    cmd.clear = s_accept && (s_axis_tuser == ACT_CLEAR);
    if ((state == S_SCAN) && dv) begin
      if ((act == ACT_BEGIN) && rd_active && (rd_entry.count != '0)) begin
        cmd.write      = 1'b1;
        wr_entry.count = rd_entry.count - COUNT_W'(1);
      end
      if ((act == ACT_END) && rd_active && (rd_entry.count == '0)) begin
        cmd.deactivate = 1'b1;
      end
    end
    if (state == S_UPDATE) begin
      wr_entry.freq  = peak_freq;
      wr_entry.proto = peak_proto;
      wr_entry.chan  = peak_chan;
      if (match) begin
        cmd.write      = 1'b1;
        wr_addr        = hit;
        wr_entry.count = sat_count;
      end else if (free) begin
        cmd.write      = 1'b1;
        cmd.activate   = 1'b1;
        wr_addr        = free_idx;
        wr_entry.count = COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RESET;
      thr       <= THR_RESET;
      band_low  <= BAND_LOW_RESET;
      band_high <= BAND_HIGH_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_TOLERANCE: tol       <= cfg_data[TOL_W-1:0];
        CFG_THRESHOLD: thr       <= cfg_data[THR_W-1:0];
        CFG_BAND_LOW:  band_low  <= cfg_data[FREQ_W-1:0];
        CFG_BAND_HIGH: band_high <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issue_cnt     <= '0;
      dv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      dv   <= rd_en;
      didx <= issue_cnt[IW-1:0];
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            act        <= s_axis_tuser;
            peak_freq  <= s_axis_tdata[21:0];
            peak_proto <= s_axis_tdata[29:22];
            peak_chan  <= s_axis_tdata[37:30];
            idx        <= s_axis_tdata[41:38];
            issue_cnt  <= '0;
            match      <= 1'b0;
            free       <= 1'b0;
            outcome    <= OUTC_DONE;
            slot       <= '0;
            total      <= '0;
            us         <= '0;
            e_entry    <= '0;
            e_active   <= 1'b0;
            if ((s_axis_tuser == ACT_BEGIN) || (s_axis_tuser == ACT_PEAK) ||
                (s_axis_tuser == ACT_END)) begin
              state <= S_SCAN;
            end else begin
              state <= S_COUNT;
            end
          end
        end
        S_SCAN: begin
          if (dv && (act == ACT_PEAK)) begin
            if (!match && rd_active && near) begin
              match     <= 1'b1;
              hit       <= didx;
              hit_count <= rd_entry.count;
            end
            if (!free && (!rd_active || (rd_entry.count == '0))) begin
              free     <= 1'b1;
              free_idx <= didx;
            end
          end
          if (pass_done) begin
            issue_cnt <= '0;
            state     <= (act == ACT_PEAK) ? S_UPDATE : S_COUNT;
          end else if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
        end
        S_UPDATE: begin
          if (match) begin
            outcome <= OUTC_MATCHED;
            slot    <= SLOT_W'(hit);
          end else if (free) begin
            outcome <= OUTC_ALLOC;
            slot    <= SLOT_W'(free_idx);
          end else begin
            outcome <= OUTC_DROPPED;
          end
          state <= S_COUNT;
        end
        S_COUNT: begin
          if (act == ACT_READ) begin
            slot <= idx;
          end
          if (dv) begin
            if (persistent) begin
              if (total != TOTAL_MAX) begin
                total <= total + TOTAL_W'(1);
              end
              if (in_band && (us != TOTAL_MAX)) begin
                us <= us + TOTAL_W'(1);
              end
            end
            if ((act == ACT_READ) && (CMPW'(didx) == CMPW'(idx))) begin
              e_entry  <= rd_entry;
              e_active <= rd_active;
            end
          end
          if (pass_done) begin
            state <= S_OUT;
          end else if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            res_outcome   <= outcome;
            res_slot      <= slot;
            res_total     <= total;
            res_us        <= us;
            res_entry     <= e_entry;
            res_active    <= e_active;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tuser = res_outcome;
  assign m_axis_tdata = {3'b000, res_active, res_entry.count, res_entry.chan,
                         res_entry.proto, res_entry.freq, res_us, res_total, res_slot};

`ifndef ASSERT_OFF
  a_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> ((state == S_SCAN) || (state == S_UPDATE)))
    else $error("table write outside scan or update");

  a_us_le_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_us <= res_total))
    else $error("band count exceeds total count");

  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (res_outcome == OUTC_DROPPED)) |-> (res_slot == '0))
    else $error("dropped peak reports a slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_axis_tready)
    else $error("ready right after accept");

  a_entry_only_on_read: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid) && (act != ACT_READ)) |-> ((res_entry == '0) && !res_active))
    else $error("entry fields set for non-read item");
`endif

endmodule

>>> test/tracker_checker.sv
// Checker for the signal persistence tracker: tracks the table, predicts each result item, compares.
module tracker_checker import spt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  // low to high: peak_frequency_khz, protocol_id, channel_number, entry_index, zero pad
  input  logic [47:0]           in_data,
  // action
  input  logic [ACT_W-1:0]      in_user,
  input  logic                  out_valid,
  input  logic                  out_ready,
  // low to high: slot, persistent_total, persistent_us, entry frequency, protocol,
  // channel, count, active, zero pad
  input  logic [63:0]           out_data,
  // outcome
  input  logic [OUTC_W-1:0]     out_user,
  output int                    mismatches,
  output int                    awaited
);

  typedef struct packed {
    logic [OUTC_W-1:0]  outcome;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] in_band;
    logic [FREQ_W-1:0]  freq;
    logic [PROTO_W-1:0] proto;
    logic [CHAN_W-1:0]  chan;
    logic [COUNT_W-1:0] count;
    logic               active;
  } report_t;

  logic [TOL_W-1:0]   tol_khz;
  logic [THR_W-1:0]   thr;
  logic [FREQ_W-1:0]  band_lo;
  logic [FREQ_W-1:0]  band_hi;

  logic [FREQ_W-1:0]  tab_freq  [DEPTH];
  logic [PROTO_W-1:0] tab_proto [DEPTH];
  logic [CHAN_W-1:0]  tab_chan  [DEPTH];
  logic [COUNT_W-1:0] tab_hits  [DEPTH];
  logic               tab_live  [DEPTH];

  report_t awaited_reports [$];
  int      results_seen;

  task automatic wipe_table();
    for (int t = 0; t < DEPTH; t++) begin
      tab_freq[t]  = '0;
      tab_proto[t] = '0;
      tab_chan[t]  = '0;
      tab_hits[t]  = '0;
      tab_live[t]  = 1'b0;
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Applies one action to the table copy and works out the result item it produces.
  task automatic track_action(input logic [ACT_W-1:0] act, input logic [FREQ_W-1:0] f,
                              input logic [PROTO_W-1:0] p, input logic [CHAN_W-1:0] c,
                              input logic [SLOT_W-1:0] idx, output report_t r);
    int hit;
    logic [FREQ_W-1:0]  gap_khz;
    logic [COUNT_W:0]   bumped;
    r = '0;
    hit = -1;
    case (act)
      ACT_BEGIN: begin
        for (int t = 0; t < DEPTH; t++)
          if (tab_live[t] && tab_hits[t] != '0)
            tab_hits[t] = tab_hits[t] - COUNT_W'(1);
      end
      ACT_PEAK: begin
        for (int t = 0; t < DEPTH; t++) begin
          if (hit < 0 && tab_live[t]) begin
            gap_khz = (f >= tab_freq[t]) ? f - tab_freq[t] : tab_freq[t] - f;
            if (gap_khz < FREQ_W'(tol_khz))
              hit = t;
          end
        end
        if (hit >= 0) begin
          bumped = {1'b0, tab_hits[hit]} + (COUNT_W+1)'(2);
          tab_hits[hit]  = bumped[COUNT_W] ? COUNT_MAX : bumped[COUNT_W-1:0];
          tab_freq[hit]  = f;
          tab_proto[hit] = p;
          tab_chan[hit]  = c;
          r.outcome = OUTC_MATCHED;
          r.slot = SLOT_W'(hit);
        end else begin
          for (int t = 0; t < DEPTH; t++)
            if (hit < 0 && (!tab_live[t] || tab_hits[t] == '0))
              hit = t;
          if (hit >= 0) begin
            tab_freq[hit]  = f;
            tab_proto[hit] = p;
            tab_chan[hit]  = c;
            tab_hits[hit]  = COUNT_W'(1);
            tab_live[hit]  = 1'b1;
            r.outcome = OUTC_ALLOC;
            r.slot = SLOT_W'(hit);
          end else begin
            r.outcome = OUTC_DROPPED;
          end
        end
      end
      ACT_END: begin
        for (int t = 0; t < DEPTH; t++)
          if (tab_live[t] && tab_hits[t] == '0)
            tab_live[t] = 1'b0;
      end
      ACT_CLEAR: wipe_table();
      ACT_READ: begin
        r.slot = idx;
        if (int'(idx) < DEPTH) begin
          r.freq   = tab_freq[idx];
          r.proto  = tab_proto[idx];
          r.chan   = tab_chan[idx];
          r.count  = tab_hits[idx];
          r.active = tab_live[idx];
        end
      end
      default: ;
    endcase

    // persistence counts, taken after the action
    for (int t = 0; t < DEPTH; t++) begin
      if (tab_live[t] && tab_proto[t] != '0 && tab_hits[t] >= thr) begin
        if (r.total != TOTAL_MAX)
          r.total = r.total + TOTAL_W'(1);
        if (tab_freq[t] >= band_lo && tab_freq[t] <= band_hi && r.in_band != TOTAL_MAX)
          r.in_band = r.in_band + TOTAL_W'(1);
      end
    end
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      wipe_table();
      tol_khz = TOL_RESET;
      thr     = THR_RESET;
      band_lo = BAND_LOW_RESET;
      band_hi = BAND_HIGH_RESET;
      awaited_reports.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_TOLERANCE: tol_khz = cfg_data[TOL_W-1:0];
          CFG_THRESHOLD: thr     = cfg_data[THR_W-1:0];
          CFG_BAND_LOW:  band_lo = cfg_data[FREQ_W-1:0];
          CFG_BAND_HIGH: band_hi = cfg_data[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got.outcome = out_user;
        got.slot    = out_data[3:0];
        got.total   = out_data[8:4];
        got.in_band = out_data[13:9];
        got.freq    = out_data[35:14];
        got.proto   = out_data[43:36];
        got.chan    = out_data[51:44];
        got.count   = out_data[59:52];
        got.active  = out_data[60];
        if (awaited_reports.size() == 0) begin
          report("result item with no item pending");
        end else begin
          want = awaited_reports.pop_front();
          check_field("outcome", 32'(got.outcome), 32'(want.outcome));
          check_field("slot", 32'(got.slot), 32'(want.slot));
          check_field("persistent_total", 32'(got.total), 32'(want.total));
          check_field("persistent_us", 32'(got.in_band), 32'(want.in_band));
          check_field("entry_frequency_khz", 32'(got.freq), 32'(want.freq));
          check_field("entry_protocol_id", 32'(got.proto), 32'(want.proto));
          check_field("entry_channel", 32'(got.chan), 32'(want.chan));
          check_field("entry_count", 32'(got.count), 32'(want.count));
          check_field("entry_active", 32'(got.active), 32'(want.active));
        end
      end
      if (in_valid && in_ready) begin
        track_action(in_user, in_data[21:0], in_data[29:22], in_data[37:30], in_data[41:38],
                     want);
        awaited_reports.push_back(want);
      end
    end
    awaited <= awaited_reports.size();
  end

endmodule

>>> test/tb.sv
// Testbench top for the signal persistence tracker: clock, reset, stimulus and verdict.
module tb;
  import spt_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SWEEP_ITEMS   = 165;
  localparam logic [FREQ_W-1:0] FREQ_TOP = 22'h3FFFFF;
  localparam logic [ACT_W-1:0]  ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0]  ACT_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;
  logic [ACT_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;
  logic [OUTC_W-1:0]     m_axis_tuser;

  int mismatches;
  int awaited;
  int sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stalls_served = 0;
  int hold_left = 0;
  logic [FREQ_W-1:0] band_lo_now = BAND_LOW_RESET;
  logic [FREQ_W-1:0] band_hi_now = BAND_HIGH_RESET;
  logic [FREQ_W-1:0] last_freq = '0;

  signal_persistence_tracker_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tracker_checker track_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_user    (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stall_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [FREQ_W-1:0] f,
                           input logic [PROTO_W-1:0] p, input logic [CHAN_W-1:0] c,
                           input logic [SLOT_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'b0, idx, c, p, f};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_peak(input logic [FREQ_W-1:0] f, input logic [PROTO_W-1:0] p,
                           input logic [CHAN_W-1:0] c);
    send_item(ACT_PEAK, f, p, c, SLOT_W'($urandom_range(0, 15)));
  endtask

  task automatic send_bare(input logic [ACT_W-1:0] act);
    send_item(act, FREQ_W'($urandom_range(0, FREQ_TOP)), PROTO_W'($urandom_range(0, 255)),
              CHAN_W'($urandom_range(0, 255)), SLOT_W'($urandom_range(0, 15)));
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] idx);
    send_item(ACT_READ, FREQ_W'($urandom_range(0, FREQ_TOP)), PROTO_W'($urandom_range(0, 255)),
              CHAN_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Junk above each register's width must be ignored.
  task automatic program_regs(input logic [TOL_W-1:0] tol, input logic [THR_W-1:0] thr,
                              input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= {6'($urandom), tol};
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= {14'($urandom), thr};
    @(posedge clk);
    cfg_index <= CFG_BAND_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_BAND_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    band_lo_now = lo;
    band_hi_now = hi;
  endtask

  // Mostly clustered around the band so that tracks match, repeat and fill the table.
  function automatic logic [FREQ_W-1:0] pick_freq();
    int roll;
    logic [FREQ_W-1:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      f = FREQ_W'(900000 + 1250 * $urandom_range(0, 23) + $urandom_range(0, 600) - 300);
    end else if (roll < 65) begin
      f = last_freq;
    end else if (roll < 85) begin
      f = FREQ_W'($urandom_range(0, FREQ_TOP));
    end else begin
      case ($urandom_range(0, 5))
        0: f = '0;
        1: f = FREQ_TOP;
        2: f = band_lo_now;
        3: f = band_hi_now;
        4: f = band_lo_now - FREQ_W'(1);
        default: f = band_hi_now + FREQ_W'(1);
      endcase
    end
    last_freq = f;
    return f;
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    if ($urandom_range(0, 3) == 0)
      return '0;
    return PROTO_W'($urandom_range(1, 255));
  endfunction

  task automatic run_sweeps(input int items);
    int target;
    int roll;
    target = sent + items;
    while (sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        send_bare(ACT_BEGIN);
        repeat ($urandom_range(0, 20)) begin
          if ($urandom_range(0, 19) == 0)
            send_read(SLOT_W'($urandom_range(0, 15)));
          else
            send_peak(pick_freq(), pick_proto(), CHAN_W'($urandom_range(0, 255)));
        end
        send_bare(ACT_END);
        if ($urandom_range(0, 3) == 0)
          send_read(SLOT_W'($urandom_range(0, 15)));
      end else if (roll < 86) begin
        send_read(SLOT_W'($urandom_range(0, 15)));
      end else if (roll < 89) begin
        send_bare(ACT_CLEAR);
      end else if (roll < 94) begin
        send_bare(ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
      end else if (roll < 96) begin
        send_bare(ACT_BEGIN);
      end else if (roll < 98) begin
        send_bare(ACT_END);
      end else begin
        send_peak(pick_freq(), pick_proto(), CHAN_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 52;

    // directed: reset settings, tolerance edge, band edges, expiry, spare actions, clear
    send_read(4'd0);
    send_read(4'd15);
    send_bare(ACT_BEGIN);
    send_peak(22'd902000, 8'd1, 8'd0);
    send_peak(22'd902199, 8'd255, 8'd255);
    send_peak(22'd902399, 8'd2, 8'd1);
    send_peak(22'd928000, 8'd3, 8'd2);
    send_peak(22'd928000, 8'd3, 8'd2);
    send_peak(22'd928001, 8'd0, 8'd3);
    send_peak(22'd0, 8'd4, 8'd4);
    send_peak(FREQ_TOP, 8'd5, 8'd5);
    send_bare(ACT_END);
    send_bare(ACT_BEGIN);
    send_bare(ACT_BEGIN);
    send_bare(ACT_END);
    send_read(4'd1);
    send_read(4'd0);
    send_bare(ACT_SPARE_LO);
    send_bare(ACT_SPARE_LO + ACT_W'(1));
    send_bare(ACT_SPARE_HI);
    send_bare(ACT_CLEAR);
    send_read(4'd0);

    for (int k = 0; k < 6; k++) begin
      if (k == 2) begin
        send_idle_pct = 52;
        recv_idle_pct = 22;
      end else if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k)
        0: program_regs(TOL_RESET, THR_RESET, BAND_LOW_RESET, BAND_HIGH_RESET);
        1: program_regs(16'd1, 8'd255, 22'd0, FREQ_TOP);
        2: program_regs(16'hFFFF, 8'd1, FREQ_TOP, 22'd0);
        3: program_regs(16'd5000, 8'd0, 22'd900000, 22'd930000);
        4: program_regs(TOL_W'($urandom_range(1, 65535)), THR_W'($urandom_range(1, 255)),
                        22'(880000 + $urandom_range(0, 35000)),
                        22'(915000 + $urandom_range(0, 40000)));
        default: program_regs(TOL_RESET, THR_RESET, BAND_LOW_RESET, BAND_HIGH_RESET);
      endcase
      if (k == 0)
        stall_requests++;
      if (k == 1) begin
        // one track driven into count saturation
        send_bare(ACT_CLEAR);
        repeat (130) send_peak(22'd915000, 8'd7, 8'd9);
        send_read(4'd0);
      end
      run_sweeps(SWEEP_ITEMS);
    end

    wait_drained();
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
